[design/sbep_pkg.sv]
`timescale 1ns / 1ps
// sbep_pkg: shared types, constants and the character code table of the packer.
// Used by every module of the packer; depends on nothing.
package sbep_pkg;

   localparam int MAX_MESSAGE_BYTES = 8192;
   localparam int LIMIT_W = 14;
   localparam int TOTAL_W = 14;
   localparam logic [LIMIT_W-1:0] OUT_LIMIT_RESET = 14'd8000;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0] CODE_ESC = 6'd63;
   localparam logic [5:0] CODE_SPACE = 6'd62;
   localparam logic [7:0] LOWER_BASE = 8'd26;
   localparam logic [7:0] DIGIT_BASE = 8'd52;

   // classified item: up to three candidate bytes, left-aligned, and their count
   typedef struct packed {
      logic [23:0] bytes;
      logic [1:0]  n_bytes;
      logic        last;
   } entry_type;

   function automatic logic [5:0] code_of(input logic [7:0] ch);
      logic [5:0] code;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         code = 6'(ch - 8'h41);
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         code = 6'(ch - 8'h61 + LOWER_BASE);
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         code = 6'(ch - 8'h30 + DIGIT_BASE);
      end else if (ch == 8'h20) begin
         code = CODE_SPACE;
      end else begin
         code = CODE_ESC;
      end
      return code;
   endfunction

endpackage

[design/sbep_front.sv]
`timescale 1ns / 1ps
// sbep_front: maps each character to its code and splits the bit stream into bytes.
// Depends on sbep_pkg.
module sbep_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          char_byte,
   input  logic                last_char,
   output sbep_pkg::entry_type entry
);

   logic [6:0]  acc_ff, acc_in;
   logic [2:0]  held_ff, held_in;
   logic [5:0]  code;
   logic        esc;
   logic [4:0]  nb;
   logic [20:0] value;
   logic [23:0] aligned;
   logic [2:0]  rem;

   always_comb begin
      code    = sbep_pkg::code_of(char_byte);
      esc     = (code == sbep_pkg::CODE_ESC);
      nb      = 5'(held_ff) + (esc ? 5'd14 : 5'd6);
      value   = esc ? {acc_ff, code, char_byte} : {8'd0, acc_ff, code};
      aligned = 24'(value) << (5'd24 - nb);
      rem     = nb[2:0];
      entry.bytes   = aligned;
      entry.n_bytes = nb[4:3] + 2'(last_char && (rem != 3'd0));
      entry.last    = last_char;
      acc_in  = acc_ff;
      held_in = held_ff;
      if (accept) begin
         if (last_char) begin
            acc_in  = 7'd0;
            held_in = 3'd0;
         end else begin
            acc_in  = value[6:0] & ~(7'h7F << rem);
            held_in = rem;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= 7'd0;
         held_ff <= 3'd0;
      end else begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
      end
   end

endmodule

[design/sbep_queue.sv]
`timescale 1ns / 1ps
// sbep_queue: short queue of classified items between the front and back parts.
// Depends on sbep_pkg.
module sbep_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_en,
   input  sbep_pkg::entry_type push_entry,
   input  logic                pop_en,
   output sbep_pkg::entry_type head,
   output logic                head_valid,
   output logic                q_full
);

   sbep_pkg::entry_type              store_ff [sbep_pkg::QUEUE_DEPTH];
   logic [sbep_pkg::QPTR_W-1:0]      wptr_ff, wptr_in;
   logic [sbep_pkg::QPTR_W-1:0]      rptr_ff, rptr_in;
   logic [sbep_pkg::QCNT_W-1:0]      cnt_ff, cnt_in;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      cnt_in  = cnt_ff;
      if (push_en) begin
         wptr_in = (wptr_ff == sbep_pkg::QPTR_W'(sbep_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wptr_ff + 1'b1;
      end
      if (pop_en) begin
         rptr_in = (rptr_ff == sbep_pkg::QPTR_W'(sbep_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rptr_ff + 1'b1;
      end
      if (push_en && !pop_en) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop_en && !push_en) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   assign head       = store_ff[rptr_ff];
   assign head_valid = (cnt_ff != '0);
   assign q_full     = (cnt_ff == sbep_pkg::QCNT_W'(sbep_pkg::QUEUE_DEPTH));

   always_ff @(posedge clock) begin
      if (push_en) begin
         store_ff[wptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

[design/sbep_back.sv]
`timescale 1ns / 1ps
// sbep_back: sends queued bytes one a cycle unless the output stalls, counts them against the
// limit and marks ends. Depends on sbep_pkg; holds the result register.
module sbep_back #(
   parameter int MAX_MESSAGE_BYTES = sbep_pkg::MAX_MESSAGE_BYTES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  sbep_pkg::entry_type                 head,
   input  logic                                head_valid,
   output logic                                head_pop,
   input  logic [sbep_pkg::LIMIT_W-1:0]        out_limit,
   input  logic                                rsp_pop,
   output logic                                rsp_valid,
   output logic [7:0]                          rsp_out_byte,
   output logic                                rsp_byte_valid,
   output logic                                rsp_last_of_item,
   output logic                                rsp_message_end,
   output logic                                rsp_overflow,
   output logic [sbep_pkg::TOTAL_W-1:0]        rsp_total_bytes
);

   localparam int CW = $clog2(MAX_MESSAGE_BYTES + 1);
   localparam int LW = (CW > sbep_pkg::LIMIT_W) ? CW :
                       ((sbep_pkg::TOTAL_W > sbep_pkg::LIMIT_W) ? sbep_pkg::TOTAL_W :
                        sbep_pkg::LIMIT_W);

   logic [CW-1:0]  count_ff, count_in;
   logic           aborted_ff, aborted_in;
   logic [1:0]     idx_ff, idx_in;
   logic           valid_ff, valid_in;
   logic [7:0]     byte_ff, byte_in;
   logic           bv_ff, bv_in;
   logic           loi_ff, loi_in;
   logic           end_ff, end_in;
   logic           ovf_ff, ovf_in;
   logic [sbep_pkg::TOTAL_W-1:0] tot_ff, tot_in;
   logic [LW-1:0]  lim_w;
   logic [LW-1:0]  tot_wide;
   logic           at_limit;
   logic           step;
   logic           load;
   logic           clear;
   logic [7:0]     byte_sel;

   always_comb begin
      lim_w = (LW'(out_limit) > LW'(MAX_MESSAGE_BYTES)) ?
              LW'(MAX_MESSAGE_BYTES) : LW'(out_limit);
      at_limit = (LW'(count_ff) >= lim_w);
      case (idx_ff)
         2'd0:    byte_sel = head.bytes[23:16];
         2'd1:    byte_sel = head.bytes[15:8];
         default: byte_sel = head.bytes[7:0];
      endcase
   end

   always_comb begin
      step       = head_valid && (!valid_ff || rsp_pop);
      head_pop   = 1'b0;
      load       = 1'b0;
      clear      = 1'b0;
      count_in   = count_ff;
      aborted_in = aborted_ff;
      idx_in     = idx_ff;
      byte_in    = 8'd0;
      bv_in      = 1'b0;
      loi_in     = 1'b0;
      end_in     = 1'b0;
      ovf_in     = 1'b0;
      tot_wide   = LW'(count_ff);
      if (step) begin
         if (aborted_ff) begin
            // drop the rest of the message, mark its end
            head_pop = 1'b1;
            if (head.last) begin
               load   = 1'b1;
               loi_in = 1'b1;
               end_in = 1'b1;
               ovf_in = 1'b1;
               clear  = 1'b1;
            end
         end else if (idx_ff < head.n_bytes) begin
            if (at_limit) begin
               load     = 1'b1;
               loi_in   = 1'b1;
               end_in   = head.last;
               ovf_in   = 1'b1;
               head_pop = 1'b1;
               idx_in   = 2'd0;
               if (head.last) begin
                  clear = 1'b1;
               end else begin
                  aborted_in = 1'b1;
               end
            end else begin
               load     = 1'b1;
               bv_in    = 1'b1;
               byte_in  = byte_sel;
               count_in = count_ff + 1'b1;
               tot_wide = LW'(count_ff) + 1'b1;
               if (idx_ff == head.n_bytes - 2'd1) begin
                  loi_in   = 1'b1;
                  end_in   = head.last;
                  head_pop = 1'b1;
                  idx_in   = 2'd0;
                  clear    = head.last;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end else begin
            head_pop = 1'b1;
            if (head.last) begin
               load   = 1'b1;
               loi_in = 1'b1;
               end_in = 1'b1;
               clear  = 1'b1;
            end
         end
      end
      if (clear) begin
         count_in   = '0;
         aborted_in = 1'b0;
      end
      tot_in   = tot_wide[sbep_pkg::TOTAL_W-1:0];
      valid_in = load || (valid_ff && !rsp_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         aborted_ff <= 1'b0;
         idx_ff     <= 2'd0;
         valid_ff   <= 1'b0;
      end else begin
         count_ff   <= count_in;
         aborted_ff <= aborted_in;
         idx_ff     <= idx_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         bv_ff   <= bv_in;
         loi_ff  <= loi_in;
         end_ff  <= end_in;
         ovf_ff  <= ovf_in;
         tot_ff  <= tot_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_byte_valid   = bv_ff;
   assign rsp_last_of_item = loi_ff;
   assign rsp_message_end  = end_ff;
   assign rsp_overflow     = ovf_ff;
   assign rsp_total_bytes  = tot_ff;

endmodule

[design/six_bit_escape_packer_top.sv]
`timescale 1ns / 1ps
// Six-bit escape packer: a character in each word on the req side, packed bytes and end
// markers on the rsp side; out_limit loaded through the csr channel (always ready).
// A character is taken in the cycle it arrives while the two-entry item queue has room;
// the back part then puts out one result word a cycle while the rsp side pops; a character
// yields at most one byte for a letter, digit or space, up to two for an escaped byte, and
// up to three result words at a message end. The first result of a character passes
// through the item queue and the back result register. Reset leaves no clearing pass.
// Depends on sbep_pkg, sbep_front, sbep_queue and sbep_back.
module six_bit_escape_packer_top #(
   parameter int MAX_MESSAGE_BYTES = sbep_pkg::MAX_MESSAGE_BYTES
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   output logic                          full,
   input  logic [7:0]                    req_char_byte,
   input  logic                          req_last_char,
   output logic                          empty,
   input  logic                          pop,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_byte_valid,
   output logic                          rsp_last_of_item,
   output logic                          rsp_message_end,
   output logic                          rsp_overflow,
   output logic [sbep_pkg::TOTAL_W-1:0]  rsp_total_bytes,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sbep_pkg::LIMIT_W-1:0]  csr_out_limit
);

   logic [sbep_pkg::LIMIT_W-1:0] out_limit_ff, out_limit_in;
   logic                         accept;
   sbep_pkg::entry_type          new_entry;
   sbep_pkg::entry_type          head;
   logic                         head_valid;
   logic                         head_pop;
   logic                         q_full;
   logic                         rsp_valid;

   assign csr_ready    = 1'b1;
   assign out_limit_in = (csr_valid && csr_ready) ? csr_out_limit : out_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_limit_ff <= sbep_pkg::OUT_LIMIT_RESET;
      end else begin
         out_limit_ff <= out_limit_in;
      end
   end

   assign full   = q_full;
   assign accept = push && !q_full;
   assign empty  = !rsp_valid;

   sbep_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .char_byte (req_char_byte),
      .last_char (req_last_char),
      .entry     (new_entry)
   );

   sbep_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (accept),
      .push_entry (new_entry),
      .pop_en     (head_pop),
      .head       (head),
      .head_valid (head_valid),
      .q_full     (q_full)
   );

   sbep_back #(
      .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_valid       (head_valid),
      .head_pop         (head_pop),
      .out_limit        (out_limit_ff),
      .rsp_pop          (pop),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_message_end  (rsp_message_end),
      .rsp_overflow     (rsp_overflow),
      .rsp_total_bytes  (rsp_total_bytes)
   );

   a_ovf_no_byte : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_overflow) |-> !rsp_byte_valid)
      else $error("overflow marker carries a byte");

   a_end_is_item_end : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_message_end) |-> rsp_last_of_item)
      else $error("message end without item end");

   a_byte_counted : assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_byte_valid) |-> (rsp_total_bytes != '0))
      else $error("packed byte with zero count");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not empty after reset");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for six_bit_escape_packer_top: directed, overflow and random messages.
// Predicts every packed word in-line and checks the rsp side word by word; needs sbep_pkg.
module testbench;

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0]                   out_byte;
      logic                         byte_valid;
      logic                         last_of_item;
      logic                         message_end;
      logic                         overflow;
      logic [sbep_pkg::TOTAL_W-1:0] total_bytes;
   } packed_word_type;

   logic                         clock;
   logic                         reset;
   logic                         push;
   logic                         full;
   logic [7:0]                   req_char_byte;
   logic                         req_last_char;
   logic                         empty;
   logic                         pop;
   logic [7:0]                   rsp_out_byte;
   logic                         rsp_byte_valid;
   logic                         rsp_last_of_item;
   logic                         rsp_message_end;
   logic                         rsp_overflow;
   logic [sbep_pkg::TOTAL_W-1:0] rsp_total_bytes;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [sbep_pkg::LIMIT_W-1:0] csr_out_limit;

   packed_word_type    expected_words[$];
   int unsigned        mismatches;
   int unsigned        quiet_cycles;
   bit                 steady;

   // predictor state
   logic [20:0]                  pk_acc;
   logic [4:0]                   pk_held;
   logic [sbep_pkg::TOTAL_W-1:0] pk_count;
   logic                         pk_aborted;
   logic [sbep_pkg::LIMIT_W-1:0] pk_limit;

   six_bit_escape_packer_top DUT (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_char_byte    (req_char_byte),
      .req_last_char    (req_last_char),
      .empty            (empty),
      .pop              (pop),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last_of_item (rsp_last_of_item),
      .rsp_message_end  (rsp_message_end),
      .rsp_overflow     (rsp_overflow),
      .rsp_total_bytes  (rsp_total_bytes),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_out_limit    (csr_out_limit)
   );

   always #10 clock = ~clock;

   function automatic logic [5:0] six_bit_code(input logic [7:0] ch);
      if (ch >= 8'h41 && ch <= 8'h5A) return 6'(ch - 8'h41);
      if (ch >= 8'h61 && ch <= 8'h7A) return 6'(ch - 8'h61 + 8'd26);
      if (ch >= 8'h30 && ch <= 8'h39) return 6'(ch - 8'h30 + 8'd52);
      if (ch == 8'h20) return sbep_pkg::CODE_SPACE;
      return sbep_pkg::CODE_ESC;
   endfunction

   function automatic packed_word_type make_word(input logic [7:0] b, input logic valid,
                                                 input logic ovf,
                                                 input logic [sbep_pkg::TOTAL_W-1:0] total);
      packed_word_type w;
      w.out_byte     = b;
      w.byte_valid   = valid;
      w.last_of_item = 1'b0;
      w.message_end  = 1'b0;
      w.overflow     = ovf;
      w.total_bytes  = total;
      return w;
   endfunction

   task automatic clear_message_state();
      pk_acc     = '0;
      pk_held    = '0;
      pk_count   = '0;
      pk_aborted = 1'b0;
   endtask

   task automatic pack_char(input logic [7:0] ch, input logic last);
      packed_word_type              words[$];
      packed_word_type              w;
      logic [5:0]                   code;
      logic [sbep_pkg::LIMIT_W-1:0] cap;
      logic                         ovf;
      cap = (pk_limit > sbep_pkg::LIMIT_W'(sbep_pkg::MAX_MESSAGE_BYTES)) ?
            sbep_pkg::LIMIT_W'(sbep_pkg::MAX_MESSAGE_BYTES) : pk_limit;
      ovf = 1'b0;
      if (pk_aborted) begin
         if (last) words.push_back(make_word(8'h00, 1'b0, 1'b1, pk_count));
      end else begin
         code = six_bit_code(ch);
         pk_acc = {pk_acc[14:0], code};
         pk_held = pk_held + 5'd6;
         if (code == sbep_pkg::CODE_ESC) begin
            pk_acc = {pk_acc[12:0], ch};
            pk_held = pk_held + 5'd8;
         end
         while (pk_held >= 5'd8 && !ovf) begin
            if (pk_count >= cap) begin
               ovf = 1'b1;
            end else begin
               pk_count = pk_count + 1'b1;
               words.push_back(make_word(8'(pk_acc >> (pk_held - 5'd8)), 1'b1, 1'b0, pk_count));
               pk_held = pk_held - 5'd8;
            end
         end
         if (!ovf && last && pk_held != 5'd0) begin
            if (pk_count >= cap) begin
               ovf = 1'b1;
            end else begin
               pk_count = pk_count + 1'b1;
               words.push_back(make_word(8'(pk_acc << (5'd8 - pk_held)), 1'b1, 1'b0, pk_count));
               pk_held = 5'd0;
            end
         end
         pk_acc = pk_acc & ((21'd1 << pk_held) - 21'd1);
         if (ovf) begin
            words.push_back(make_word(8'h00, 1'b0, 1'b1, pk_count));
            pk_acc     = '0;
            pk_held    = '0;
            pk_aborted = 1'b1;
         end else if (last && words.size() == 0) begin
            words.push_back(make_word(8'h00, 1'b0, 1'b0, pk_count));
         end
      end
      if (words.size() != 0) begin
         w = words.pop_back();
         w.last_of_item = 1'b1;
         if (last) w.message_end = 1'b1;
         words.push_back(w);
      end
      if (last) clear_message_state();
      foreach (words[i]) expected_words.push_back(words[i]);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic send_char(input logic [7:0] ch, input logic last);
      @(negedge clock);
      while (!steady && $urandom_range(0, 99) < 30) begin
         push <= 1'b0;
         @(negedge clock);
      end
      push          <= 1'b1;
      req_char_byte <= ch;
      req_last_char <= last;
      do @(posedge clock); while (full);
      pack_char(ch, last);
   endtask

   // hold input until every expected word is out and the pipe has drained
   task automatic settle_outputs();
      @(negedge clock);
      push <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [sbep_pkg::LIMIT_W-1:0] value);
      settle_outputs();
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_out_limit <= value;
      do @(posedge clock); while (!csr_ready);
      pk_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] random_char();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'(8'h41 + $urandom_range(0, 25));
         3, 4:    return 8'(8'h61 + $urandom_range(0, 25));
         5:       return 8'(8'h30 + $urandom_range(0, 9));
         6:       return 8'h20;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic test_char_classes();
      send_char(8'h41, 1'b0);
      send_char(8'h5A, 1'b0);
      send_char(8'h61, 1'b0);
      send_char(8'h7A, 1'b0);
      send_char(8'h30, 1'b0);
      send_char(8'h39, 1'b0);
      send_char(8'h20, 1'b0);
      send_char(8'h00, 1'b0);
      send_char(8'hFF, 1'b1);
      send_char(8'h41, 1'b1);
      send_char(8'h41, 1'b0);
      send_char(8'h40, 1'b1);
      send_char(8'h5B, 1'b0);
      send_char(8'h60, 1'b0);
      send_char(8'h7B, 1'b0);
      send_char(8'h2F, 1'b0);
      send_char(8'h3A, 1'b1);
      settle_outputs();
   endtask

   task automatic test_overflow();
      write_limit(14'd0);
      send_char(8'h41, 1'b1);
      send_char(8'h42, 1'b0);
      send_char(8'h43, 1'b0);
      send_char(8'h44, 1'b1);
      write_limit(14'd1);
      send_char(8'hFF, 1'b0);
      send_char(8'h71, 1'b1);
      write_limit(14'd2);
      send_char(8'h41, 1'b0);
      send_char(8'h42, 1'b0);
      send_char(8'h43, 1'b0);
      send_char(8'h44, 1'b1);
      settle_outputs();
   endtask

   task automatic run_random_phase(input logic [sbep_pkg::LIMIT_W-1:0] value, input int n_items,
                                   input int max_len, input bit quiet);
      int sent;
      int len;
      write_limit(value);
      steady = quiet;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3 * max_len)
                                           : $urandom_range(1, max_len);
         for (int k = 0; k < len; k++) begin
            send_char(random_char(), k == len - 1);
            if (k == len / 2 && $urandom_range(0, 5) == 0) settle_outputs();
         end
         sent += len;
      end
      settle_outputs();
      steady = 1'b0;
   endtask

   task automatic test_random_messages();
      run_random_phase(14'd8192, 80, 12, 1'b1);
      run_random_phase(14'd0, 20, 3, 1'b0);
      run_random_phase(14'd1, 35, 4, 1'b0);
      run_random_phase(14'd6, 70, 10, 1'b0);
      run_random_phase(14'($urandom_range(2, 30)), 70, 12, 1'b0);
      run_random_phase(sbep_pkg::OUT_LIMIT_RESET, 80, 12, 1'b0);
   endtask

   always @(negedge clock) begin
      pop <= steady || ($urandom_range(0, 99) >= 30);
   end

   always @(posedge clock) begin : check_words
      packed_word_type want;
      if (!reset && pop && !empty) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_out_byte, -1);
         end else begin
            want = expected_words.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch("out_byte", rsp_out_byte, want.out_byte);
            if (rsp_byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", rsp_byte_valid, want.byte_valid);
            if (rsp_last_of_item !== want.last_of_item)
               report_mismatch("last_of_item", rsp_last_of_item, want.last_of_item);
            if (rsp_message_end !== want.message_end)
               report_mismatch("message_end", rsp_message_end, want.message_end);
            if (rsp_overflow !== want.overflow)
               report_mismatch("overflow", rsp_overflow, want.overflow);
            if (rsp_total_bytes !== want.total_bytes)
               report_mismatch("total_bytes", rsp_total_bytes, want.total_bytes);
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      push          = 1'b0;
      pop           = 1'b0;
      req_char_byte = '0;
      req_last_char = 1'b0;
      csr_valid     = 1'b0;
      csr_out_limit = '0;
      steady        = 1'b0;
      mismatches    = 0;
      quiet_cycles  = 0;
      clear_message_state();
      pk_limit = sbep_pkg::OUT_LIMIT_RESET;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_char_classes();
      test_overflow();
      test_random_messages();

      settle_outputs();
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
